### rtl/core/rrps_pkg.sv
`timescale 1ns / 1ps
package rrps_pkg;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_TERM    = 2'd3
  } ent_state_t;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_TERM   = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    KEY_TARGET = 2'd0,
    KEY_POP    = 2'd1,
    KEY_CUR    = 2'd2
  } key_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND_TERM,
    S_TERM_UPD,
    S_POP,
    S_POP_WAIT,
    S_FIND_DISP,
    S_DISP,
    S_PRE_CHK,
    S_FIND_PRE,
    S_PREEMPT,
    S_PURGE,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic [31:0] id;
    ent_state_t  st;
  } entry_t;

  typedef struct packed {
    logic     capture;
    logic     res_clear;
    logic     do_create;
    logic     tick_inc;
    logic     scan_clear;
    key_sel_t key_sel;
    logic     scan_run;
    logic     term_mark;
    logic     term_miss;
    logic     pop;
    logic     dispatch;
    logic     preempt;
    logic     purge_run;
  } dp_ctl_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      fifo_empty;
    logic      cur_zero;
    logic      scan_done;
    logic      found;
    logic      found_ready;
    logic      found_running;
    logic      slice_hit;
    logic      purge_done;
  } dp_sts_t;

  localparam logic [15:0] SLICE_RESET = 16'd10;
  localparam int EV_DISPATCH = 0;
  localparam int EV_PREEMPT  = 1;

endpackage

### rtl/core/rrps_ram.sv
`timescale 1ns / 1ps
module rrps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rrps_ctrl.sv
`timescale 1ns / 1ps
module rrps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  rrps_pkg::dp_sts_t sts,
  output rrps_pkg::dp_ctl_t ctl,
  output logic             busy,
  output logic             out_valid
);
  import rrps_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_CREATE: state_nxt = S_DONE;
          CMD_TERM:   state_nxt = S_FIND_TERM;
          CMD_TICK: begin
            if (sts.fifo_empty) state_nxt = S_DONE;
            else if (sts.cur_zero) state_nxt = S_POP;
            else state_nxt = S_PRE_CHK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIND_TERM: begin
        if (sts.scan_done) state_nxt = S_TERM_UPD;
      end
      S_TERM_UPD: state_nxt = S_DONE;
      S_POP:      state_nxt = S_POP_WAIT;
      S_POP_WAIT: state_nxt = S_FIND_DISP;
      S_FIND_DISP: begin
        if (sts.scan_done) state_nxt = S_DISP;
      end
      S_DISP: state_nxt = S_PRE_CHK;
      S_PRE_CHK: begin
        if (sts.cur_zero) state_nxt = S_PURGE;
        else state_nxt = S_FIND_PRE;
      end
      S_FIND_PRE: begin
        if (sts.scan_done) state_nxt = S_PREEMPT;
      end
      S_PREEMPT: state_nxt = S_PURGE;
      S_PURGE: begin
        if (sts.purge_done) state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.key_sel = KEY_TARGET;
    busy = (state_r != S_IDLE);
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        ctl.capture = start;
      end
      S_DECODE: begin
        ctl.res_clear  = 1'b1;
        ctl.do_create  = (sts.cmd == CMD_CREATE);
        ctl.tick_inc   = (sts.cmd == CMD_TICK);
        ctl.scan_clear = 1'b1;
        ctl.key_sel    = KEY_TARGET;
      end
      S_FIND_TERM: ctl.scan_run = 1'b1;
      S_TERM_UPD: begin
        ctl.term_mark = sts.found;
        ctl.term_miss = !sts.found;
      end
      S_POP: ctl.pop = 1'b1;
      S_POP_WAIT: begin
        ctl.scan_clear = 1'b1;
        ctl.key_sel    = KEY_POP;
      end
      S_FIND_DISP: ctl.scan_run = 1'b1;
      S_DISP: begin
        ctl.dispatch = sts.found && sts.found_ready;
      end
      S_PRE_CHK: begin
        ctl.scan_clear = 1'b1;
        ctl.key_sel    = KEY_CUR;
      end
      S_FIND_PRE: ctl.scan_run = 1'b1;
      S_PREEMPT: begin
        ctl.preempt    = sts.found && sts.found_running && sts.slice_hit;
        ctl.scan_clear = 1'b1;
        ctl.key_sel    = KEY_CUR;
      end
      S_PURGE: ctl.purge_run = 1'b1;
      S_DONE:  out_valid = 1'b1;
      default: ctl = '0;
    endcase
  end

endmodule

### rtl/core/rrps_dp.sv
`timescale 1ns / 1ps
module rrps_dp #(
  parameter int TABLE_DEPTH = 16,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [1:0]                         in_cmd,
  input  logic [31:0]                        in_target_id,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_wdata,
  input  rrps_pkg::dp_ctl_t                  ctl,
  output rrps_pkg::dp_sts_t                  sts,
  output logic [1:0]                         out_status,
  output logic [31:0]                        out_new_id,
  output logic [31:0]                        out_running_id,
  output logic [1:0]                         out_event_res,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   out_process_count,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_ready_count,
  output logic                               out_queue_overflow
);
  import rrps_pkg::*;

  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW  = $bits(entry_t);

  cmd_code_t    cmd_r;
  logic [31:0]  target_r;
  logic [31:0]  key_r;
  logic [15:0]  slice_r;
  logic [31:0]  current_r;
  logic [31:0]  next_id_r;
  logic [15:0]  elapsed_r;
  logic [TCW-1:0] count_r;
  logic [QAW-1:0] head_r;
  logic [QCW-1:0] fill_r;
  logic [TCW-1:0] scan_idx_r;
  logic         rd_vld_r;
  logic [TAW-1:0] rd_idx_r;
  logic         found_r;
  logic [TAW-1:0] found_idx_r;
  ent_state_t   found_st_r;
  logic [TCW-1:0] w_r;
  status_code_t status_r;
  logic [31:0]  new_id_r;
  logic [1:0]   event_r;
  logic         ovf_r;

  logic           t_we;
  logic [TAW-1:0] t_waddr;
  entry_t         t_wdata;
  logic [EW-1:0]  t_rdata_raw;
  entry_t         t_rdata;
  logic           issue;
  logic           hit;
  logic           scan_end;
  logic           purge_we;
  logic           table_full;
  logic           create_ok;

  logic           fifo_full;
  logic           push_req;
  logic           push_ok;
  logic [31:0]    push_id;
  logic [QCW:0]   slot_sum;
  logic [QCW:0]   slot_wrap;
  logic [31:0]    q_rdata;
  logic [31:0]    key_mux;

  assign t_rdata    = entry_t'(t_rdata_raw);
  assign table_full = (count_r == TCW'(TABLE_DEPTH));
  assign create_ok  = ctl.do_create && !table_full;
  assign scan_end   = !rd_vld_r && (scan_idx_r >= count_r);
  assign issue      = ((ctl.scan_run && !found_r) || ctl.purge_run) && (scan_idx_r < count_r);
  assign hit        = ctl.scan_run && !found_r && rd_vld_r && (t_rdata.id == key_r);
  assign purge_we   = ctl.purge_run && rd_vld_r && (t_rdata.st != ST_TERM);

  assign fifo_full = (fill_r == QCW'(QUEUE_DEPTH));
  assign push_req  = create_ok || ctl.preempt;
  assign push_ok   = push_req && !fifo_full;
  assign push_id   = ctl.preempt ? current_r : next_id_r;
  assign slot_sum  = (QCW+1)'(head_r) + (QCW+1)'(fill_r);
  assign slot_wrap = (slot_sum >= (QCW+1)'(QUEUE_DEPTH)) ?
                     slot_sum - (QCW+1)'(QUEUE_DEPTH) : slot_sum;

  always_comb begin
    case (ctl.key_sel)
      KEY_TARGET: key_mux = target_r;
      KEY_POP:    key_mux = q_rdata;
      KEY_CUR:    key_mux = current_r;
      default:    key_mux = current_r;
    endcase
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = found_idx_r;
    t_wdata = '{id: key_r, st: ST_TERM};
    if (create_ok) begin
      t_we    = 1'b1;
      t_waddr = count_r[TAW-1:0];
      t_wdata = '{id: next_id_r, st: ST_READY};
    end else if (ctl.term_mark) begin
      t_we    = 1'b1;
      t_wdata = '{id: target_r, st: ST_TERM};
    end else if (ctl.dispatch) begin
      t_we    = 1'b1;
      t_wdata = '{id: key_r, st: ST_RUNNING};
    end else if (ctl.preempt) begin
      t_we    = 1'b1;
      t_wdata = '{id: key_r, st: ST_READY};
    end else if (purge_we) begin
      t_we    = 1'b1;
      t_waddr = w_r[TAW-1:0];
      t_wdata = t_rdata;
    end
  end

  rrps_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (EW'(t_wdata)),
    .re    (issue),
    .raddr (scan_idx_r[TAW-1:0]),
    .rdata (t_rdata_raw)
  );

  rrps_ram #(
    .WIDTH (32),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (push_ok),
    .waddr (slot_wrap[QAW-1:0]),
    .wdata (push_id),
    .re    (ctl.pop),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r    <= SLICE_RESET;
      current_r  <= '0;
      next_id_r  <= 32'd1;
      elapsed_r  <= '0;
      count_r    <= '0;
      head_r     <= '0;
      fill_r     <= '0;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      w_r        <= '0;
    end else begin
      if (cfg_we) slice_r <= cfg_wdata;

      if (create_ok) begin
        next_id_r <= (next_id_r == '1) ? 32'd1 : next_id_r + 32'd1;
      end

      if (create_ok) begin
        count_r <= count_r + 1'b1;
      end else if (ctl.purge_run && scan_end) begin
        count_r <= w_r;
      end

      if (ctl.dispatch) begin
        current_r <= key_r;
      end else if (ctl.preempt) begin
        current_r <= '0;
      end else if (ctl.term_mark && (current_r == target_r)) begin
        current_r <= '0;
      end

      if (ctl.dispatch || ctl.preempt) begin
        elapsed_r <= '0;
      end else if (ctl.tick_inc && (current_r != '0) && (elapsed_r != '1)) begin
        elapsed_r <= elapsed_r + 16'd1;
      end

      if (ctl.pop) begin
        head_r <= (head_r == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end else if (push_ok) begin
        fill_r <= fill_r + 1'b1;
      end

      if (ctl.scan_clear) begin
        scan_idx_r <= '0;
        rd_vld_r   <= 1'b0;
        found_r    <= 1'b0;
        w_r        <= '0;
      end else begin
        if (issue) scan_idx_r <= scan_idx_r + 1'b1;
        rd_vld_r <= issue;
        if (hit) found_r <= 1'b1;
        if (purge_we) w_r <= w_r + 1'b1;
      end
    end
  end

  // request payload, scan payload and results
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r    <= cmd_code_t'(in_cmd);
      target_r <= in_target_id;
    end
    if (ctl.scan_clear) key_r <= key_mux;
    rd_idx_r <= scan_idx_r[TAW-1:0];
    if (hit) begin
      found_idx_r <= rd_idx_r;
      found_st_r  <= t_rdata.st;
    end
    if (ctl.res_clear) begin
      status_r <= (ctl.do_create && table_full) ? STAT_FULL : STAT_OK;
      new_id_r <= create_ok ? next_id_r : 32'd0;
      event_r  <= 2'b00;
      ovf_r    <= push_req && fifo_full;
    end else begin
      if (ctl.term_miss) status_r <= STAT_NOT_FOUND;
      if (ctl.dispatch) event_r[EV_DISPATCH] <= 1'b1;
      if (ctl.preempt) event_r[EV_PREEMPT] <= 1'b1;
      if (ctl.preempt && fifo_full) ovf_r <= 1'b1;
    end
  end

  assign sts.cmd           = cmd_r;
  assign sts.fifo_empty    = (fill_r == '0);
  assign sts.cur_zero      = (current_r == '0);
  assign sts.scan_done     = found_r || scan_end;
  assign sts.found         = found_r;
  assign sts.found_ready   = (found_st_r == ST_READY);
  assign sts.found_running = (found_st_r == ST_RUNNING);
  assign sts.slice_hit     = (elapsed_r >= slice_r);
  assign sts.purge_done    = scan_end;

  assign out_status         = status_r;
  assign out_new_id         = new_id_r;
  assign out_running_id     = current_r;
  assign out_event_res      = event_r;
  assign out_process_count  = count_r;
  assign out_ready_count    = fill_r;
  assign out_queue_overflow = ovf_r;

endmodule

### rtl/core/round_robin_process_scheduler_unit.sv
`timescale 1ns / 1ps
// one request at a time; busy stays high from accept until the result strobe
// create and unused codes finish right after decode; terminate sweeps the table once
// tick, unless the ready queue is empty, is set by table ram sweeps
// (lookups of the popped and the running id, then the compaction pass)
// out_valid is high for one cycle per request; the receiver cannot stall
// synchronous active-low reset: table and queue empty, idle, next id 1, slice 10
module round_robin_process_scheduler_unit #(
  parameter int TABLE_DEPTH = 16,
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_cmd,
  input  logic [31:0]                        in_target_id,
  input  logic                               cfg_we,
  input  logic [15:0]                        cfg_wdata,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [31:0]                        out_new_id,
  output logic [31:0]                        out_running_id,
  output logic [1:0]                         out_event_res,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   out_process_count,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   out_ready_count,
  output logic                               out_queue_overflow
);
  import rrps_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  rrps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rrps_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cmd             (in_cmd),
    .in_target_id       (in_target_id),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .ctl                (ctl),
    .sts                (sts),
    .out_status         (out_status),
    .out_new_id         (out_new_id),
    .out_running_id     (out_running_id),
    .out_event_res      (out_event_res),
    .out_process_count  (out_process_count),
    .out_ready_count    (out_ready_count),
    .out_queue_overflow (out_queue_overflow)
  );

endmodule

### tb/round_robin_process_scheduler_unit_test.sv
`timescale 1ns / 1ps
module round_robin_process_scheduler_unit_test;
  import rrps_pkg::*;

  localparam int TBL_N = 16;
  localparam int QUE_N = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] target;
    logic        aim_live;
  } sched_req_t;

  typedef struct packed {
    status_code_t status;
    logic [31:0]  new_id;
    logic [31:0]  running_id;
    logic [1:0]   ev;
    logic [4:0]   pcount;
    logic [5:0]   rcount;
    logic         ovf;
  } sched_outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = 2'd0;
  logic [31:0] in_target_id = 32'd0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_new_id;
  logic [31:0] out_running_id;
  logic [1:0]  out_event_res;
  logic [4:0]  out_process_count;
  logic [5:0]  out_ready_count;
  logic        out_queue_overflow;

  round_robin_process_scheduler_unit #(
    .TABLE_DEPTH(TBL_N),
    .QUEUE_DEPTH(QUE_N)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_target_id      (in_target_id),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_new_id        (out_new_id),
    .out_running_id    (out_running_id),
    .out_event_res     (out_event_res),
    .out_process_count (out_process_count),
    .out_ready_count   (out_ready_count),
    .out_queue_overflow(out_queue_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler mirror
  logic [31:0] tbl_id [TBL_N];
  ent_state_t  tbl_st [TBL_N];
  logic [31:0] ready_ring [QUE_N];
  int          ring_head;
  int          ring_fill;
  logic [31:0] cur_id;
  logic [31:0] nxt_id;
  logic [15:0] elapsed;
  logic [15:0] slice_len;

  sched_req_t     request_backlog[$];
  sched_outcome_t awaited_outcomes[$];
  sched_req_t     head_req;
  sched_outcome_t got_out;
  sched_outcome_t want_out;

  int gap_pct = 36;
  int queued_total = 0;
  int accepted_total = 0;
  int checked_total = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int dispatch_seen = 0;
  int preempt_seen = 0;
  int overflow_seen = 0;
  int full_seen = 0;
  int missing_seen = 0;

  function automatic void clear_mirror();
    for (int i = 0; i < TBL_N; i++) begin
      tbl_id[i] = '0;
      tbl_st[i] = ST_INVALID;
    end
    for (int i = 0; i < QUE_N; i++) ready_ring[i] = '0;
    ring_head = 0;
    ring_fill = 0;
    cur_id = '0;
    nxt_id = 32'd1;
    elapsed = '0;
    slice_len = SLICE_RESET;
  endfunction

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < TBL_N; i++) if (tbl_st[i] != ST_INVALID) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < TBL_N; i++)
      if (tbl_st[i] != ST_INVALID && tbl_id[i] == id) return i;
    return TBL_N;
  endfunction

  function automatic bit ring_push(logic [31:0] id);
    if (ring_fill >= QUE_N) return 1'b0;
    ready_ring[(ring_head + ring_fill) % QUE_N] = id;
    ring_fill++;
    return 1'b1;
  endfunction

  function automatic void drop_terminated();
    int w;
    w = 0;
    for (int i = 0; i < TBL_N; i++) begin
      if (tbl_st[i] != ST_INVALID && tbl_st[i] != ST_TERM) begin
        tbl_id[w] = tbl_id[i];
        tbl_st[w] = tbl_st[i];
        w++;
      end
    end
    for (int i = w; i < TBL_N; i++) begin
      tbl_st[i] = ST_INVALID;
      tbl_id[i] = '0;
    end
  endfunction

  function automatic sched_outcome_t schedule_request(logic [1:0] cmd, logic [31:0] tgt);
    sched_outcome_t r;
    int n;
    int k;
    logic [31:0] pid;
    r = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_CREATE: begin
        n = held_count();
        if (n >= TBL_N) begin
          r.status = STAT_FULL;
        end else begin
          r.new_id = nxt_id;
          nxt_id = nxt_id + 32'd1;
          if (nxt_id == 32'd0) nxt_id = 32'd1;
          tbl_id[n] = r.new_id;
          tbl_st[n] = ST_READY;
          if (!ring_push(r.new_id)) r.ovf = 1'b1;
        end
      end
      CMD_TICK: begin
        if (cur_id != 0 && elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
        if (ring_fill != 0) begin
          if (cur_id == 0) begin
            pid = ready_ring[ring_head];
            ring_head = (ring_head + 1) % QUE_N;
            ring_fill--;
            k = find_slot(pid);
            if (k < TBL_N && tbl_st[k] == ST_READY) begin
              cur_id = pid;
              tbl_st[k] = ST_RUNNING;
              elapsed = '0;
              r.ev[EV_DISPATCH] = 1'b1;
            end
          end
          if (cur_id != 0) begin
            k = find_slot(cur_id);
            if (k < TBL_N && tbl_st[k] == ST_RUNNING && elapsed >= slice_len) begin
              tbl_st[k] = ST_READY;
              if (!ring_push(cur_id)) r.ovf = 1'b1;
              cur_id = '0;
              elapsed = '0;
              r.ev[EV_PREEMPT] = 1'b1;
            end
          end
          drop_terminated();
        end
      end
      CMD_TERM: begin
        k = find_slot(tgt);
        if (k < TBL_N) begin
          tbl_st[k] = ST_TERM;
          if (cur_id == tgt) cur_id = '0;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    r.running_id = cur_id;
    r.pcount = 5'(held_count());
    r.rcount = 6'(ring_fill);
    return r;
  endfunction

  // pick a terminate target among the ids the table holds right now, or a small random id if it holds none
  function automatic logic [31:0] live_target();
    int n;
    n = held_count();
    if (cur_id != 0 && $urandom_range(3) == 0) return cur_id;
    if (n == 0) return 32'($urandom_range(1, 8));
    return tbl_id[$urandom_range(n - 1)];
  endfunction

  function automatic void queue_req(logic [1:0] cmd, logic [31:0] tgt, logic live);
    sched_req_t q;
    q.cmd = cmd;
    q.target = tgt;
    q.aim_live = live;
    request_backlog.push_back(q);
    queued_total++;
  endfunction

  function automatic void queue_mix(int count, int pct_create, int pct_kill);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < pct_create) begin
        queue_req(CMD_CREATE, $urandom, 1'b0);
      end else if (r < pct_create + pct_kill) begin
        queue_req(CMD_TERM, '0, 1'b1);
      end else if (r < pct_create + pct_kill + 4) begin
        case ($urandom_range(2))
          0: queue_req(CMD_TERM, '0, 1'b0);
          1: queue_req(CMD_TERM, $urandom, 1'b0);
          default: queue_req(CMD_TERM, 32'($urandom_range(60)), 1'b0);
        endcase
      end else if (r < pct_create + pct_kill + 6) begin
        queue_req(CMD_UNUSED, $urandom, 1'b0);
      end else begin
        queue_req(CMD_TICK, $urandom, 1'b0);
      end
    end
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < 100)
      $display("mismatch at cycle %0d, %s: expected %0h, got %0h",
               cycle_count, what, want, got);
    mismatch_count++;
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || awaited_outcomes.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_slice(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    slice_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_cmd <= CMD_CREATE;
      in_target_id <= '0;
    end else begin
      if (start && !busy) begin
        awaited_outcomes.push_back(schedule_request(in_cmd, in_target_id));
        accepted_total++;
      end
      if (!start || !busy) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          head_req = request_backlog.pop_front();
          in_cmd <= head_req.cmd;
          in_target_id <= head_req.aim_live ? live_target() : head_req.target;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_out.status = status_code_t'(out_status);
      got_out.new_id = out_new_id;
      got_out.running_id = out_running_id;
      got_out.ev = out_event_res;
      got_out.pcount = out_process_count;
      got_out.rcount = out_ready_count;
      got_out.ovf = out_queue_overflow;
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch("result with no request pending", '0, {30'd0, out_status});
      end else begin
        want_out = awaited_outcomes.pop_front();
        checked_total++;
        if (got_out.status != want_out.status)
          flag_mismatch("status", 32'(want_out.status), 32'(got_out.status));
        if (got_out.new_id != want_out.new_id)
          flag_mismatch("new_id", want_out.new_id, got_out.new_id);
        if (got_out.running_id != want_out.running_id)
          flag_mismatch("running_id", want_out.running_id, got_out.running_id);
        if (got_out.ev != want_out.ev)
          flag_mismatch("event_res", 32'(want_out.ev), 32'(got_out.ev));
        if (got_out.pcount != want_out.pcount)
          flag_mismatch("process_count", 32'(want_out.pcount), 32'(got_out.pcount));
        if (got_out.rcount != want_out.rcount)
          flag_mismatch("ready_count", 32'(want_out.rcount), 32'(got_out.rcount));
        if (got_out.ovf != want_out.ovf)
          flag_mismatch("queue_overflow", 32'(want_out.ovf), 32'(got_out.ovf));
        if (want_out.ev[EV_DISPATCH]) dispatch_seen++;
        if (want_out.ev[EV_PREEMPT]) preempt_seen++;
        if (want_out.ovf) overflow_seen++;
        if (want_out.status == STAT_FULL) full_seen++;
        if (want_out.status == STAT_NOT_FOUND) missing_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("round_robin_process_scheduler_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    clear_mirror();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed request sequence at the reset slice
    queue_req(CMD_TERM, 32'd0, 1'b0);
    queue_req(CMD_TICK, 32'hFFFF_FFFF, 1'b0);
    queue_req(CMD_UNUSED, 32'hFFFF_FFFF, 1'b0);
    queue_req(CMD_CREATE, 32'h0, 1'b0);
    queue_req(CMD_CREATE, 32'hFFFF_FFFF, 1'b0);
    queue_req(CMD_TERM, 32'hFFFF_FFFF, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_req(CMD_TERM, 32'd2, 1'b0);
    queue_req(CMD_TERM, 32'd2, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_req(CMD_TERM, 32'd1, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_req(CMD_CREATE, 32'h0, 1'b0);
    queue_req(CMD_TERM, 32'h8000_0000, 1'b0);
    queue_req(CMD_TERM, 32'h7FFF_FFFF, 1'b0);
    wait_drained();

    // zero slice: dispatch and preempt in one tick
    set_slice(16'd0);
    queue_req(CMD_CREATE, 32'h0, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_req(CMD_TICK, 32'h0, 1'b0);
    queue_mix(220, 30, 15);
    wait_drained();

    set_slice(16'd1);
    queue_mix(220, 30, 15);
    wait_drained();

    gap_pct = 0;
    set_slice(16'd3);
    queue_mix(240, 30, 15);
    wait_drained();
    gap_pct = 36;

    set_slice(16'hFFFF);
    queue_mix(200, 35, 15);
    wait_drained();

    // rare ticks let stale ids pile up in the queue
    set_slice(16'd2);
    queue_mix(300, 45, 40);
    wait_drained();

    set_slice(16'd10);
    queue_mix(250, 35, 15);
    wait_drained();

    set_slice(16'($urandom_range(5)));
    queue_mix(250, 30, 15);
    wait_drained();

    set_slice(16'($urandom_range(20)));
    queue_mix(250, 40, 25);
    wait_drained();

    repeat (70) @(posedge clk);
    if (awaited_outcomes.size() != 0)
      flag_mismatch("results never delivered", '0, awaited_outcomes.size());
    $display("requests %0d, results checked %0d, slices from 0 to 65535",
             accepted_total, checked_total);
    $display("dispatches %0d, preemptions %0d, queue overflows %0d, table full %0d, unknown id %0d",
             dispatch_seen, preempt_seen, overflow_seen, full_seen, missing_seen);
    if (mismatch_count == 0) begin
      $display("round_robin_process_scheduler_unit_test OK");
    end else begin
      $display("round_robin_process_scheduler_unit_test NOT OK");
    end
    $finish;
  end

endmodule
